### rtl/tcwg_pkg.sv
`default_nettype none

package tcwg_pkg;

    // Fixed field widths of the streaming payload
    localparam int unsigned FieldBits   = 30;
    localparam int unsigned SegBits     = 16;
    localparam int unsigned InDataBits  = 96;
    localparam int unsigned OutDataBits = 32;

    // Arithmetic width of the growth path and the divider
    localparam int unsigned CalcBits    = 32;
    localparam int unsigned DivCntBits  = $clog2(CalcBits);

    // Segment size after reset
    localparam logic [SegBits-1:0] SegReset = 16'd1460;

    // Configuration register indexes
    localparam logic RegSegmentSize = 1'b0;

    // Operation codes carried in tuser
    localparam logic OpAck  = 1'b0;
    localparam logic OpLoad = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic start_div;
        logic div_step;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/tcwg_ctrl.sv
`default_nettype none

module tcwg_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire tcwg_pkg::t_sts i_sts,
    output tcwg_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a transaction only when no item is in flight
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.need_div ? S_MUL : S_UPDATE;
            end
            S_MUL: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/tcwg_dp.sv
`default_nettype none

module tcwg_dp #(
    parameter int unsigned WINDOW_BITS = 30
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire tcwg_pkg::t_cmd                 i_cmd,
    output tcwg_pkg::t_sts                      o_sts,
    input  wire [tcwg_pkg::SegBits-1:0]         i_seg,
    input  wire                                 i_op,
    input  wire [tcwg_pkg::FieldBits-1:0]       i_ssthresh,
    input  wire                                 i_fast,
    input  wire [tcwg_pkg::FieldBits-1:0]       i_adv,
    input  wire [tcwg_pkg::FieldBits-1:0]       i_new_window,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [tcwg_pkg::FieldBits-1:0]      o_window,
    output logic                                o_at_limit
);

    localparam int unsigned CB = tcwg_pkg::CalcBits;
    localparam int unsigned FB = tcwg_pkg::FieldBits;
    localparam int unsigned DB = tcwg_pkg::DivCntBits;
    localparam logic [CB:0] WinMax = (33'd1 << WINDOW_BITS) - 33'd1;

    // Window state
    logic [WINDOW_BITS-1:0] r_cong;
    logic                   r_stop;

    // Latched item
    logic          r_op;
    logic          r_fast;
    logic [FB-1:0] r_ssth;
    logic [FB-1:0] r_adv;
    logic [FB-1:0] r_neww;

    // Divider
    logic [CB:0]   r_rem;
    logic [CB-1:0] r_quo;
    logic [DB-1:0] r_cnt;

    // Output register
    logic          r_out_valid;
    logic [FB-1:0] r_out_win;
    logic          r_out_lim;

    logic [CB-1:0] w_sq;
    logic [CB-1:0] w_cong32;
    logic [CB-1:0] w_thr32;
    logic [CB-1:0] w_adv32;
    logic [CB-1:0] w_load32;
    logic          w_slow;
    logic [CB-1:0] w_inc;
    logic [CB:0]   w_sum;
    logic [CB-1:0] w_sat;
    logic [CB-1:0] w_grown;
    logic [CB-1:0] n_cong32;
    logic          n_stop;
    logic [CB:0]   w_trial;
    logic          w_ge;
    logic          w_out_free;

    // Square of the segment size, registered into the divider
    assign w_sq = i_seg * i_seg;

    assign w_cong32 = CB'(r_cong);
    assign w_thr32  = CB'(r_ssth);
    assign w_adv32  = CB'(r_adv);
    assign w_load32 = CB'(WINDOW_BITS'(CB'(r_neww)));

    assign w_slow     = (w_cong32 < w_thr32) || r_fast;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Growth: one segment in slow start or for an empty window, else quotient
    assign w_inc   = (!w_slow && (w_cong32 != '0)) ? r_quo : CB'(i_seg);
    assign w_sum   = {1'b0, w_cong32} + {1'b0, w_inc};
    assign w_sat   = (w_sum > WinMax) ? WinMax[CB-1:0] : w_sum[CB-1:0];
    assign w_grown = r_stop ? w_cong32 : w_sat;

    // Select the new window and limit flag
    always_comb begin
        priority if (r_op == tcwg_pkg::OpLoad) begin
            n_cong32 = w_load32;
            n_stop   = r_stop;
        end else if (w_slow) begin
            n_cong32 = w_grown;
            n_stop   = r_stop || (w_grown == w_adv32);
        end else begin
            n_cong32 = w_grown;
            n_stop   = !(w_grown < w_adv32);
        end
    end

    // One restoring divide step
    assign w_trial = {r_rem[CB-1:0], r_quo[CB-1]};
    assign w_ge    = (w_trial >= {1'b0, w_cong32});

    assign o_sts.need_div = (r_op == tcwg_pkg::OpAck) && !w_slow && !r_stop
                            && (w_cong32 != '0);
    assign o_sts.div_done = (r_cnt == DB'(CB - 1));
    assign o_sts.out_free = w_out_free;

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_fast <= i_fast;
            r_ssth <= i_ssthresh;
            r_adv  <= i_adv;
            r_neww <= i_new_window;
        end
    end

    // Iterate the divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_rem <= '0;
            r_quo <= w_sq;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_trial - {1'b0, w_cong32}) : w_trial;
            r_quo <= {r_quo[CB-2:0], w_ge};
            r_cnt <= r_cnt + DB'(1);
        end
    end

    // Commit window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cong <= '0;
            r_stop <= 1'b0;
        end else if (i_cmd.commit) begin
            r_cong <= n_cong32[WINDOW_BITS-1:0];
            r_stop <= n_stop;
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_win <= n_cong32[FB-1:0];
            r_out_lim <= n_stop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_window    = r_out_win;
    assign o_at_limit  = r_out_lim;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result committed over a waiting result");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (w_cong32 != '0))
        else $error("divide step with zero window");

    a_div_avoid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ((r_op == tcwg_pkg::OpAck) && !w_slow && !r_stop))
        else $error("divide step outside congestion avoidance growth");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("result valid without commit");
`endif

endmodule

`default_nettype wire

### rtl/tcp_congestion_window_growth.sv
`default_nettype none

// Reno-style congestion window growth, one result per input transaction.
// An acknowledgement (tuser = 0) grows the window by one segment in slow
// start or fast recovery, and by segment*segment/window in congestion
// avoidance; a load (tuser = 1) writes new_window. An avoidance update passes
// through the 32-step restoring divider that produces one quotient bit per
// cycle; loads, slow start updates, updates of an empty window and updates
// with growth stopped skip the divider. A finished result waits in the
// output register while the next item is taken.
// segment_size sits at byte address 0 of the register port and resets to
// 1460; write it only while no item is in flight.
module tcp_congestion_window_growth #(
    parameter int unsigned WINDOW_BITS = 30
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [29:0] slow_start_threshold, [30] fast_recovery,
    // [60:31] advertised_window, [90:61] new_window, [95:91] zero
    input  wire [95:0]  i_s_axis_tdata,
    // [0] op
    input  wire [0:0]   i_s_axis_tuser,
    // master stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [29:0] window, [30] at_limit, [31] zero
    output logic [31:0] o_m_axis_tdata,
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned FB = tcwg_pkg::FieldBits;
    localparam int unsigned SB = tcwg_pkg::SegBits;

    logic [SB-1:0]  r_seg;
    tcwg_pkg::t_cmd w_cmd;
    tcwg_pkg::t_sts w_sts;
    logic [FB-1:0]  w_window;
    logic           w_at_limit;

    // Register port: single segment size register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= tcwg_pkg::SegReset;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == tcwg_pkg::RegSegmentSize)) begin
            r_seg <= pwdata[SB-1:0];
        end
    end

    assign prdata = (paddr[2] == tcwg_pkg::RegSegmentSize) ? 32'(r_seg) : '0;

    tcwg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcwg_dp #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_seg        (r_seg),
        .i_op         (i_s_axis_tuser[0]),
        .i_ssthresh   (i_s_axis_tdata[29:0]),
        .i_fast       (i_s_axis_tdata[30]),
        .i_adv        (i_s_axis_tdata[60:31]),
        .i_new_window (i_s_axis_tdata[90:61]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_window     (w_window),
        .o_at_limit   (w_at_limit)
    );

    assign o_m_axis_tdata = {1'b0, w_at_limit, w_window};

endmodule

`default_nettype wire
